// ----- src/i2p_pkg.sv -----
// Shared types, character codes and precedence table for the infix to postfix converter.
package i2p_pkg;

  typedef struct packed {
    logic [7:0] in_char;
    logic       flush;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       end_of_expr;
    logic       last;
  } out_t;

  localparam logic [2:0] KIND_OPERAND = 3'd0;
  localparam logic [2:0] KIND_LPAREN  = 3'd1;
  localparam logic [2:0] KIND_RPAREN  = 3'd2;
  localparam logic [2:0] KIND_OPER    = 3'd3;
  localparam logic [2:0] KIND_FLUSH   = 3'd4;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] ch;
    logic [2:0] prec;
  } cmd_t;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_TERM   = 8'h00;

  localparam logic [2:0] PREC_POW   = 3'd5;
  localparam logic [2:0] PREC_MUL   = 3'd4;
  localparam logic [2:0] PREC_ADD   = 3'd3;
  localparam logic [2:0] PREC_PAREN = 3'd2;
  localparam logic [2:0] PREC_OTHER = 3'd1;

  function automatic logic [2:0] prec_of(input logic [7:0] c);
    logic [2:0] p;
    unique case (c) inside
      CH_LPAREN:          p = PREC_PAREN;
      CH_CARET:           p = PREC_POW;
      CH_STAR, CH_SLASH:  p = PREC_MUL;
      CH_PLUS, CH_MINUS:  p = PREC_ADD;
      default:            p = PREC_OTHER;
    endcase
    return p;
  endfunction

endpackage

// ----- src/i2p_front.sv -----
// Front end: classifies each incoming character request into a stack command.
module i2p_front (
  input  logic          char_valid,
  output logic          char_ready,
  input  i2p_pkg::in_t  char_item,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output i2p_pkg::cmd_t cmd
);
  import i2p_pkg::*;

  logic [7:0] c;
  logic       is_alnum;

  assign c = char_item.in_char;
  assign is_alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
                    (c >= 8'h61 && c <= 8'h7A);

  always_comb begin
    cmd.ch   = c;
    cmd.prec = prec_of(c);
    if (char_item.flush) begin
      cmd.kind = KIND_FLUSH;
    end else if (is_alnum) begin
      cmd.kind = KIND_OPERAND;
    end else if (c == CH_LPAREN) begin
      cmd.kind = KIND_LPAREN;
    end else if (c == CH_RPAREN) begin
      cmd.kind = KIND_RPAREN;
    end else begin
      cmd.kind = KIND_OPER;
    end
  end

  assign cmd_valid  = char_valid;
  assign char_ready = cmd_ready;

endmodule

// ----- src/i2p_cmd_fifo.sv -----
// Two-entry command queue between the classifier and the stack engine.
module i2p_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  i2p_pkg::cmd_t wr_cmd,
  output logic          rd_valid,
  input  logic          rd_pop,
  output i2p_pkg::cmd_t rd_cmd
);
  import i2p_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_wr;
  logic       do_rd;

  assign wr_ready = (fill != 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign rd_cmd   = slots[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_wr, do_rd})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ----- src/i2p_back.sv -----
// Back end: operator stack engine, pending result holder and output register.
module i2p_back #(
  parameter int STACK_DEPTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  i2p_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          res_valid,
  input  logic          res_ready,
  output i2p_pkg::out_t res
);
  import i2p_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  localparam logic ST_RUN = 1'b0;
  localparam logic ST_FIN = 1'b1;

  logic [7:0]    mem [STACK_DEPTH];
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;
  logic [7:0]    top;
  logic          state;
  logic          state_next;
  logic          pend_valid;
  logic [7:0]    pend_char;
  logic          pend_eoe;

  logic          do_push;
  logic          do_pop;
  logic          do_emit;
  logic [7:0]    emit_char;
  logic          emit_eoe;
  logic          finish;
  logic          direct;
  logic          need_out;
  logic          out_free;
  logic          act;
  logic [2:0]    top_prec;
  logic [CW-1:0] rd_cnt;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          wr_en;

  assign top_prec = prec_of(top);
  assign out_free = !res_valid || res_ready;

  always_comb begin
    do_push   = 1'b0;
    do_pop    = 1'b0;
    do_emit   = 1'b0;
    emit_char = top;
    emit_eoe  = 1'b0;
    finish    = 1'b0;
    direct    = 1'b0;
    if (state == ST_RUN) begin
      case (cmd.kind)
        KIND_OPERAND: begin
          direct = 1'b1;
        end
        KIND_LPAREN: begin
          do_push = (cnt != FULL);
          finish  = 1'b1;
        end
        KIND_RPAREN: begin
          if (cnt != '0) begin
            do_pop = 1'b1;
            if (top == CH_LPAREN) begin
              finish = 1'b1;
            end else begin
              do_emit = 1'b1;
            end
          end else begin
            finish = 1'b1;
          end
        end
        KIND_OPER: begin
          if (cnt != '0 && top_prec >= cmd.prec) begin
            do_pop  = 1'b1;
            do_emit = 1'b1;
          end else begin
            do_push = (cnt != FULL);
            finish  = 1'b1;
          end
        end
        default: begin
          // flush: drain the stack, then emit the terminator
          if (cnt != '0) begin
            do_pop  = 1'b1;
            do_emit = 1'b1;
          end else begin
            do_emit   = 1'b1;
            emit_char = CH_TERM;
            emit_eoe  = 1'b1;
            finish    = 1'b1;
          end
        end
      endcase
    end
  end

  assign need_out = direct || (state == ST_FIN) || (do_emit && pend_valid);
  assign act      = cmd_valid && (!need_out || out_free);

  always_comb begin
    cnt_next   = cnt;
    state_next = state;
    cmd_pop    = 1'b0;
    if (act) begin
      if (do_pop) begin
        cnt_next = cnt - CW'(1);
      end else if (do_push) begin
        cnt_next = cnt + CW'(1);
      end
      if (state == ST_FIN) begin
        state_next = ST_RUN;
        cmd_pop    = 1'b1;
      end else if (direct) begin
        cmd_pop = 1'b1;
      end else if (finish) begin
        // hold the item until its pending result goes out marked last
        if (do_emit || pend_valid) begin
          state_next = ST_FIN;
        end else begin
          cmd_pop = 1'b1;
        end
      end
    end
  end

  assign wr_en   = act && do_push;
  assign wr_addr = cnt[AW-1:0];
  assign rd_cnt  = cnt_next - CW'(1);
  assign rd_addr = rd_cnt[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd.ch;
    end
  end

  // top tracks the entry under the next count while that count is nonzero, with write forwarding
  always_ff @(posedge clk) begin
    if (cnt_next != '0) begin
      if (wr_en && wr_addr == rd_addr) begin
        top <= cmd.ch;
      end else begin
        top <= mem[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      state      <= ST_RUN;
      pend_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      cnt   <= cnt_next;
      state <= state_next;
      if (act && state == ST_FIN) begin
        pend_valid <= 1'b0;
      end else if (act && do_emit) begin
        pend_valid <= 1'b1;
      end
      if (act && need_out) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (act) begin
      if (do_emit) begin
        pend_char <= emit_char;
        pend_eoe  <= emit_eoe;
      end
      if (direct) begin
        res.out_char    <= cmd.ch;
        res.end_of_expr <= 1'b0;
        res.last        <= 1'b1;
      end else if (need_out) begin
        res.out_char    <= pend_char;
        res.end_of_expr <= pend_eoe;
        res.last        <= (state == ST_FIN);
      end
    end
  end

endmodule

// ----- src/infix_to_postfix_converter_unit.sv -----
// Top level of the shunting-yard infix to postfix converter.
//
//   channel  direction  payload              handshake
//   char     in         in_t  (char, flush)   char_valid / char_ready
//   post     out        out_t (char, flags)   post_valid / post_ready
//
// A request enters a two-entry command queue; the stack engine works on one
// command at a time. An operand goes straight out; any other command pops
// stack entries one at a time as needed, then does its final push or test, and
// an item whose last result sits in the pending holder takes a closing step.
// Reset clears the stack count, the queue and the output valid flag; stack
// storage is never cleared. Either side may stall without losing requests.
module infix_to_postfix_converter_unit #(
  parameter int STACK_DEPTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          char_valid,
  output logic          char_ready,
  input  i2p_pkg::in_t  char_item,
  output logic          post_valid,
  input  logic          post_ready,
  output i2p_pkg::out_t post_item
);
  import i2p_pkg::*;

  logic cls_valid;
  logic cls_ready;
  cmd_t cls_cmd;
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  i2p_front u_front (
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_item  (char_item),
    .cmd_valid  (cls_valid),
    .cmd_ready  (cls_ready),
    .cmd        (cls_cmd)
  );

  i2p_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (cls_valid),
    .wr_ready (cls_ready),
    .wr_cmd   (cls_cmd),
    .rd_valid (q_valid),
    .rd_pop   (q_pop),
    .rd_cmd   (q_cmd)
  );

  i2p_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd       (q_cmd),
    .cmd_pop   (q_pop),
    .res_valid (post_valid),
    .res_ready (post_ready),
    .res       (post_item)
  );

endmodule

// ----- dv/infix_to_postfix_converter_unit_tb.sv -----
// Self-checking testbench for the shunting-yard infix to postfix converter.
`timescale 1ns / 1ps

module infix_to_postfix_converter_unit_tb;
  import i2p_pkg::*;

  localparam int STACK_DEPTH = 32;
  localparam int LONG_HOLD   = 300;
  localparam logic [7:0] HASH_CH  = 8'h23;
  localparam logic [7:0] SPACE_CH = 8'h20;

  logic  clk;
  logic  rst = 1'b1;
  logic  char_valid = 1'b0;
  logic  char_ready;
  in_t   char_item = '0;
  logic  post_valid;
  logic  post_ready = 1'b0;
  out_t  post_item;

  in_t   char_queue[$];
  out_t  postfix_expected[$];
  out_t  post_want;
  int    queued = 0;
  int    chars_taken = 0;
  int    flushes_taken = 0;
  int    results_seen = 0;
  int    mismatches = 0;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  logic  receiver_hold = 1'b0;
  event  hold_go;

  // operator stack as the converter should hold it
  logic [7:0] op_model [0:STACK_DEPTH-1];
  int         op_fill = 0;
  int         deepest = 0;

  logic [7:0] oper_set [6] = '{CH_CARET, CH_STAR, CH_SLASH, CH_PLUS, CH_MINUS, HASH_CH};

  infix_to_postfix_converter_unit #(
    .STACK_DEPTH(STACK_DEPTH)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .char_valid(char_valid),
    .char_ready(char_ready),
    .char_item (char_item),
    .post_valid(post_valid),
    .post_ready(post_ready),
    .post_item (post_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [2:0] rank_of(input logic [7:0] c);
    logic [2:0] r;
    r = PREC_OTHER;
    if (c == CH_CARET) r = PREC_POW;
    else if (c == CH_STAR || c == CH_SLASH) r = PREC_MUL;
    else if (c == CH_PLUS || c == CH_MINUS) r = PREC_ADD;
    else if (c == CH_LPAREN) r = PREC_PAREN;
    return r;
  endfunction

  function automatic bit is_operand(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  task automatic stack_push(input logic [7:0] c);
    // drop the push when the stack is full
    if (op_fill < STACK_DEPTH) begin
      op_model[op_fill] = c;
      op_fill++;
      if (op_fill > deepest) deepest = op_fill;
    end
  endtask

  // Work out the postfix results of one accepted request.
  task automatic shunt_char(input in_t req);
    logic [7:0] emitted[$];
    logic [7:0] top;
    logic [2:0] rank;
    bit         stop;
    out_t       res;
    stop = 1'b0;
    if (req.flush) begin
      while (op_fill > 0) begin
        op_fill--;
        emitted.push_back(op_model[op_fill]);
      end
    end else if (is_operand(req.in_char)) begin
      emitted.push_back(req.in_char);
    end else if (req.in_char == CH_LPAREN) begin
      stack_push(CH_LPAREN);
    end else if (req.in_char == CH_RPAREN) begin
      // pop to the matching paren, or until the stack runs dry
      while (op_fill > 0 && !stop) begin
        op_fill--;
        top = op_model[op_fill];
        if (top == CH_LPAREN) stop = 1'b1;
        else emitted.push_back(top);
      end
    end else begin
      rank = rank_of(req.in_char);
      while (op_fill > 0 && rank_of(op_model[op_fill-1]) >= rank) begin
        op_fill--;
        emitted.push_back(op_model[op_fill]);
      end
      stack_push(req.in_char);
    end
    for (int i = 0; i < emitted.size(); i++) begin
      res.out_char    = emitted[i];
      res.end_of_expr = 1'b0;
      res.last        = !req.flush && (i == emitted.size() - 1);
      postfix_expected.push_back(res);
    end
    if (req.flush) begin
      res.out_char    = CH_TERM;
      res.end_of_expr = 1'b1;
      res.last        = 1'b1;
      postfix_expected.push_back(res);
    end
  endtask

  // Driver: predict on acceptance, then offer the next request or idle.
  always @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (!char_valid || char_ready) begin
      if (char_valid) begin
        shunt_char(char_item);
        chars_taken++;
        if (char_item.flush) flushes_taken++;
      end
      if (char_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        char_item  <= char_queue.pop_front();
        char_valid <= 1'b1;
      end else begin
        char_valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each result with the oldest pending one.
  always @(posedge clk) begin
    if (rst) begin
      post_ready <= 1'b0;
    end else begin
      if (post_valid && post_ready) begin
        results_seen++;
        if (postfix_expected.size() == 0) begin
          $display("%0t: result with none pending: got char=%h eoe=%b last=%b", $time,
                   post_item.out_char, post_item.end_of_expr, post_item.last);
          mismatches++;
        end else begin
          post_want = postfix_expected.pop_front();
          if (post_item.out_char !== post_want.out_char ||
              post_item.end_of_expr !== post_want.end_of_expr ||
              post_item.last !== post_want.last) begin
            $display("%0t: expected char=%h eoe=%b last=%b, got char=%h eoe=%b last=%b",
                     $time, post_want.out_char, post_want.end_of_expr, post_want.last,
                     post_item.out_char, post_item.end_of_expr, post_item.last);
            mismatches++;
          end
        end
      end
      post_ready <= !receiver_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off, counted here while the sender keeps offering.
  initial begin
    @(hold_go);
    receiver_hold = 1'b1;
    repeat (LONG_HOLD) @(negedge clk);
    receiver_hold = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d results still pending", postfix_expected.size());
    $display("Mismatches found");
    $finish;
  end

  task automatic queue_item(input logic [7:0] c, input bit f);
    in_t req;
    req.in_char = c;
    req.flush   = f;
    char_queue.push_back(req);
    queued++;
  endtask

  function automatic logic [7:0] rand_operand();
    logic [7:0] c;
    case ($urandom_range(2))
      0:       c = "0" + 8'($urandom_range(9));
      1:       c = "A" + 8'($urandom_range(25));
      default: c = "a" + 8'($urandom_range(25));
    endcase
    return c;
  endfunction

  task automatic gen_term(input int depth);
    if (depth > 0 && $urandom_range(3) == 0) begin
      queue_item(CH_LPAREN, 1'b0);
      gen_expr(depth - 1);
      queue_item(CH_RPAREN, 1'b0);
    end else begin
      queue_item(rand_operand(), 1'b0);
    end
  endtask

  task automatic gen_expr(input int depth);
    int n;
    n = $urandom_range(3);
    gen_term(depth);
    repeat (n) begin
      queue_item(oper_set[$urandom_range(5)], 1'b0);
      gen_term(depth);
    end
  endtask

  // Nest "( x op" groups; each group stacks two entries.
  task automatic deep_nest(input int groups);
    repeat (groups) begin
      queue_item(CH_LPAREN, 1'b0);
      queue_item(rand_operand(), 1'b0);
      queue_item(oper_set[$urandom_range(4)], 1'b0);
    end
    queue_item(rand_operand(), 1'b0);
    repeat ($urandom_range(3)) queue_item(CH_RPAREN, 1'b0);
    queue_item(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic drain();
    do @(negedge clk);
    while (char_queue.size() != 0 || char_valid || postfix_expected.size() != 0);
  endtask

  initial begin
    logic [7:0] warmup [22] = '{"a", CH_PLUS, CH_LPAREN, "Z", CH_STAR, "9", CH_CARET, "0",
                                CH_RPAREN, CH_SLASH, "z", CH_MINUS, "A", CH_LPAREN,
                                HASH_CH, SPACE_CH, 8'h00, 8'hFF, CH_RPAREN, CH_RPAREN,
                                "b", CH_MINUS};
    int send_mix [4] = '{0, 52, 0, 35};
    int recv_mix [4] = '{0, 0, 52, 35};
    int goal;
    int kind;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // flush on an empty stack, the edge characters, then a flush with a leftover operator
    queue_item(8'hA5, 1'b1);
    foreach (warmup[i]) queue_item(warmup[i], 1'b0);
    queue_item(8'h7F, 1'b1);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = send_mix[ph];
      recv_stall_pct = recv_mix[ph];
      goal = queued + 40;
      while (queued < goal) begin
        kind = $urandom_range(15);
        if (kind < 9) begin
          gen_expr(3);
          queue_item(8'($urandom_range(255)), 1'b1);
        end else if (kind == 9) begin
          deep_nest($urandom_range(8, 17));
        end else if (kind < 12) begin
          gen_expr(2);
          repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(2))
              0:       queue_item(CH_LPAREN, 1'b0);
              1:       queue_item(CH_RPAREN, 1'b0);
              default: queue_item(oper_set[$urandom_range(5)], 1'b0);
            endcase
          end
          if ($urandom_range(1)) queue_item(8'($urandom_range(255)), 1'b1);
        end else begin
          repeat ($urandom_range(3, 8))
            queue_item(8'($urandom_range(255)), $urandom_range(7) == 0);
        end
      end
      drain();
    end

    // overflow the stack while the receiver holds off
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    -> hold_go;
    deep_nest(17);
    gen_expr(2);
    queue_item(8'($urandom_range(255)), 1'b1);
    drain();

    repeat (50) @(negedge clk);
    $display("Ran %0d characters (%0d flushes), checked %0d postfix results, stack peak %0d",
             chars_taken, flushes_taken, results_seen, deepest);
    $display("Covered four idle/stall mixes, a full-stack overflow and a long receiver hold");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
